/* hdl/mer_pkg.sv */
// Shared types and constants of the midpoint ellipse rasterizer.
// No dependencies; used by the sequencer, the datapath and the top level.
`default_nettype none

package mer_pkg;

    // Width of every coordinate in a result
    localparam int OUT_W = 12;

    // Operation codes of an input item
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Micro-operations of the shared multiplier / adder datapath
    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_RX2,       // rx2 = rx * rx
        UOP_RY2,       // ry2 = ry * ry
        UOP_TRXRY,     // t   = rx2 * ry
        UOP_Q1A,       // d   = 4*ry2 + rx2, b = 2*t, a = 0
        UOP_DSUB4T,    // d   = d - 4*t
        UOP_RND,       // d   = trunc((d + 2) / 4)
        UOP_HX2,       // t   = hx * hx
        UOP_DHX,       // d   = t * ry2
        UOP_HY2,       // t   = hy * hy
        UOP_THY,       // t   = t * rx2
        UOP_DADDT,     // d   = d + t
        UOP_RXRY,      // t   = rx2 * ry2
        UOP_CMP,       // a - b, sign to status
        UOP_AINC,      // a   = a + 2*ry2
        UOP_DADDA,     // d   = d + a
        UOP_DADDRY2,   // d   = d + ry2
        UOP_BDEC,      // b   = b - 2*rx2
        UOP_DSUBB,     // d   = d - b
        UOP_DADDRX2    // d   = d + rx2
    } uop_t;

    // Sequencer to datapath
    typedef struct packed {
        uop_t uop;
        logic load;    // capture radii of a start item
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic lt;      // a < b, valid during UOP_CMP
        logic d_neg;   // decision < 0
        logic d_pos;   // decision > 0
    } stat_t;

    // Sequencer to output register
    typedef struct packed {
        logic emit;    // load the output register this cycle
        logic pv;      // point set belongs to the ellipse
        logic last;    // point set is valid and its y offset is zero
    } emit_t;

endpackage

`default_nettype wire

/* hdl/mer_datapath.sv */
// Wide datapath: squared radii, decision and slope terms, with one shared
// multiplier and one shared adder driven by micro-ops. Depends on mer_pkg.
`default_nettype none

module mer_datapath #(
    parameter int RADIUS_BITS = 9
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mer_pkg::ctrl_t         ctrl,
    input  wire logic [RADIUS_BITS-1:0] radius_x,
    input  wire logic [RADIUS_BITS-1:0] radius_y,
    input  wire logic [RADIUS_BITS+1:0] hx,
    input  wire logic [RADIUS_BITS+1:0] hy,
    output mer_pkg::stat_t              stat
);

    localparam int RW  = RADIUS_BITS;
    localparam int SQW = 2 * RW;
    localparam int HW  = RW + 2;
    localparam int MW  = 2 * RW + 4;
    localparam int DW  = 4 * RW + 5;

    localparam logic signed [DW-1:0] RND_POS = DW'(2);
    localparam logic signed [DW-1:0] RND_NEG = DW'(5);

    logic [RW-1:0]          rx_reg, rx_next;
    logic [RW-1:0]          ry_reg, ry_next;
    logic [SQW-1:0]         rx2_reg, rx2_next;
    logic [SQW-1:0]         ry2_reg, ry2_next;
    logic signed [DW-1:0]   a_reg, a_next;
    logic signed [DW-1:0]   b_reg, b_next;
    logic signed [DW-1:0]   d_reg, d_next;
    logic signed [DW-1:0]   t_reg, t_next;

    logic [MW-1:0]          mul_a, mul_b;
    logic [2*MW-1:0]        prod;
    logic [DW-1:0]          prod_d;
    logic signed [DW-1:0]   add_x, add_y, sum;
    logic                   add_sub;

    // operand views
    logic [MW-1:0]          rx_m, ry_m, rx2_m, ry2_m, t_m, hx_m, hy_m;
    logic signed [DW-1:0]   rx2_d, ry2_d, rx2x2_d, ry2x2_d, ry2x4_d, t4_d;
    logic                   d_big_neg;

    assign rx_m  = {{(MW-RW){1'b0}}, rx_reg};
    assign ry_m  = {{(MW-RW){1'b0}}, ry_reg};
    assign rx2_m = {{(MW-SQW){1'b0}}, rx2_reg};
    assign ry2_m = {{(MW-SQW){1'b0}}, ry2_reg};
    assign t_m   = t_reg[MW-1:0];
    assign hx_m  = {{(MW-HW){1'b0}}, hx};
    assign hy_m  = {{(MW-HW){1'b0}}, hy};

    assign rx2_d   = {{(DW-SQW){1'b0}}, rx2_reg};
    assign ry2_d   = {{(DW-SQW){1'b0}}, ry2_reg};
    assign rx2x2_d = {{(DW-SQW-1){1'b0}}, rx2_reg, 1'b0};
    assign ry2x2_d = {{(DW-SQW-1){1'b0}}, ry2_reg, 1'b0};
    assign ry2x4_d = {{(DW-SQW-2){1'b0}}, ry2_reg, 2'b00};
    assign t4_d    = {t_reg[DW-3:0], 2'b00};

    // shared multiplier and adder
    assign prod   = mul_a * mul_b;
    assign prod_d = prod[DW-1:0];
    assign sum    = add_sub ? (add_x - add_y) : (add_x + add_y);

    // (d+2) is negative exactly when d is negative and not -1 or -2
    assign d_big_neg = d_reg[DW-1] && !(&d_reg[DW-1:1]);

    // micro-op decode
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        add_x    = d_reg;
        add_y    = '0;
        add_sub  = 1'b0;
        rx_next  = rx_reg;
        ry_next  = ry_reg;
        rx2_next = rx2_reg;
        ry2_next = ry2_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        d_next   = d_reg;
        t_next   = t_reg;

        if (ctrl.load)
        begin
            rx_next = radius_x;
            ry_next = radius_y;
        end

        case (ctrl.uop)
            mer_pkg::UOP_RX2:
            begin
                mul_a    = rx_m;
                mul_b    = rx_m;
                rx2_next = prod[SQW-1:0];
            end
            mer_pkg::UOP_RY2:
            begin
                mul_a    = ry_m;
                mul_b    = ry_m;
                ry2_next = prod[SQW-1:0];
            end
            mer_pkg::UOP_TRXRY:
            begin
                mul_a  = rx2_m;
                mul_b  = ry_m;
                t_next = prod_d;
            end
            mer_pkg::UOP_Q1A:
            begin
                add_x  = ry2x4_d;
                add_y  = rx2_d;
                d_next = sum;
                b_next = {t_reg[DW-2:0], 1'b0};
                a_next = '0;
            end
            mer_pkg::UOP_DSUB4T:
            begin
                add_y   = t4_d;
                add_sub = 1'b1;
                d_next  = sum;
            end
            mer_pkg::UOP_RND:
            begin
                add_y  = d_big_neg ? RND_NEG : RND_POS;
                d_next = sum >>> 2;
            end
            mer_pkg::UOP_HX2:
            begin
                mul_a  = hx_m;
                mul_b  = hx_m;
                t_next = prod_d;
            end
            mer_pkg::UOP_DHX:
            begin
                mul_a  = t_m;
                mul_b  = ry2_m;
                d_next = prod_d;
            end
            mer_pkg::UOP_HY2:
            begin
                mul_a  = hy_m;
                mul_b  = hy_m;
                t_next = prod_d;
            end
            mer_pkg::UOP_THY:
            begin
                mul_a  = t_m;
                mul_b  = rx2_m;
                t_next = prod_d;
            end
            mer_pkg::UOP_DADDT:
            begin
                add_y  = t_reg;
                d_next = sum;
            end
            mer_pkg::UOP_RXRY:
            begin
                mul_a  = rx2_m;
                mul_b  = ry2_m;
                t_next = prod_d;
            end
            mer_pkg::UOP_CMP:
            begin
                add_x   = a_reg;
                add_y   = b_reg;
                add_sub = 1'b1;
            end
            mer_pkg::UOP_AINC:
            begin
                add_x  = a_reg;
                add_y  = ry2x2_d;
                a_next = sum;
            end
            mer_pkg::UOP_DADDA:
            begin
                add_y  = a_reg;
                d_next = sum;
            end
            mer_pkg::UOP_DADDRY2:
            begin
                add_y  = ry2_d;
                d_next = sum;
            end
            mer_pkg::UOP_BDEC:
            begin
                add_x   = b_reg;
                add_y   = rx2x2_d;
                add_sub = 1'b1;
                b_next  = sum;
            end
            mer_pkg::UOP_DSUBB:
            begin
                add_y   = b_reg;
                add_sub = 1'b1;
                d_next  = sum;
            end
            mer_pkg::UOP_DADDRX2:
            begin
                add_y  = rx2_d;
                d_next = sum;
            end
            default:
            begin
            end
        endcase
    end

    // status back to the sequencer
    assign stat.lt    = sum[DW-1];
    assign stat.d_neg = d_reg[DW-1];
    assign stat.d_pos = !d_reg[DW-1] && (|d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_reg  <= '0;
            ry_reg  <= '0;
            rx2_reg <= '0;
            ry2_reg <= '0;
            a_reg   <= '0;
            b_reg   <= '0;
            d_reg   <= '0;
            t_reg   <= '0;
        end
        else
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            rx2_reg <= rx2_next;
            ry2_reg <= ry2_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
            d_reg   <= d_next;
            t_reg   <= t_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/mer_seq.sv */
// Sequencer: input handshake, region phase, x/y offsets and the micro-op
// schedule for the shared datapath. Depends on mer_pkg.
`default_nettype none

module mer_seq #(
    parameter int RADIUS_BITS = 9
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   op,
    input  wire logic [RADIUS_BITS-1:0] radius_y,
    input  wire logic                   out_free,
    input  wire mer_pkg::stat_t         stat,
    output mer_pkg::ctrl_t              ctrl,
    output mer_pkg::emit_t              emit,
    output logic [RADIUS_BITS:0]        x_off,
    output logic [RADIUS_BITS:0]        y_off,
    output logic [RADIUS_BITS+1:0]      hx,
    output logic [RADIUS_BITS+1:0]      hy
);

    localparam int RW = RADIUS_BITS;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_REG1 = 4'b0010,
        PH_REG2 = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    typedef enum logic [26:0] {
        S_IDLE  = 27'h0000001,
        S_RX2   = 27'h0000002,
        S_RY2   = 27'h0000004,
        S_TRXRY = 27'h0000008,
        S_Q1A   = 27'h0000010,
        S_Q1B   = 27'h0000020,
        S_RND1  = 27'h0000040,
        S_CMP   = 27'h0000080,
        S_R1A   = 27'h0000100,
        S_R1B   = 27'h0000200,
        S_R1C   = 27'h0000400,
        S_R1D   = 27'h0000800,
        S_R1E   = 27'h0001000,
        S_HX2   = 27'h0002000,
        S_DHX   = 27'h0004000,
        S_HY2   = 27'h0008000,
        S_THY   = 27'h0010000,
        S_DADDT = 27'h0020000,
        S_RXRY  = 27'h0040000,
        S_DSUB  = 27'h0080000,
        S_RND2  = 27'h0100000,
        S_R2A   = 27'h0200000,
        S_R2B   = 27'h0400000,
        S_R2C   = 27'h0800000,
        S_R2D   = 27'h1000000,
        S_R2E   = 27'h2000000,
        S_EMIT  = 27'h4000000
    } state_t;

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [RW:0]   x_reg, x_next;
    logic [RW:0]   y_reg, y_next;
    logic          flag_reg, flag_next;   // decision sign taken before the update
    logic          pv_reg, pv_next;
    logic [RW:0]   y_dec;

    assign in_ready = (state_reg == S_IDLE);
    assign x_off    = x_reg;
    assign y_off    = y_reg;
    assign y_dec    = y_reg - 1'b1;
    assign hx       = {x_reg, 1'b1};
    assign hy       = {y_dec, 1'b1};

    // next state and micro-op
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        flag_next  = flag_reg;
        pv_next    = pv_reg;
        ctrl.uop   = mer_pkg::UOP_NONE;
        ctrl.load  = 1'b0;
        emit.emit  = 1'b0;
        emit.pv    = pv_reg;
        emit.last  = pv_reg && (y_reg == '0);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == mer_pkg::OP_START)
                    begin
                        ctrl.load  = 1'b1;
                        x_next     = '0;
                        y_next     = {1'b0, radius_y};
                        phase_next = PH_REG1;
                        pv_next    = 1'b1;
                        state_next = S_RX2;
                    end
                    else if (phase_reg == PH_REG1)
                    begin
                        pv_next    = 1'b1;
                        state_next = S_CMP;
                    end
                    else if (phase_reg == PH_REG2)
                    begin
                        pv_next    = 1'b1;
                        state_next = S_R2A;
                    end
                    else
                    begin
                        pv_next    = 1'b0;
                        state_next = S_EMIT;
                    end
                end
            end

            // start: squares and the first decision value
            S_RX2:
            begin
                ctrl.uop   = mer_pkg::UOP_RX2;
                state_next = S_RY2;
            end
            S_RY2:
            begin
                ctrl.uop   = mer_pkg::UOP_RY2;
                state_next = S_TRXRY;
            end
            S_TRXRY:
            begin
                ctrl.uop   = mer_pkg::UOP_TRXRY;
                state_next = S_Q1A;
            end
            S_Q1A:
            begin
                ctrl.uop   = mer_pkg::UOP_Q1A;
                state_next = S_Q1B;
            end
            S_Q1B:
            begin
                ctrl.uop   = mer_pkg::UOP_DSUB4T;
                state_next = S_RND1;
            end
            S_RND1:
            begin
                ctrl.uop   = mer_pkg::UOP_RND;
                state_next = S_EMIT;
            end

            // region 1 step, or hand over to region 2
            S_CMP:
            begin
                ctrl.uop = mer_pkg::UOP_CMP;
                if (stat.lt)
                begin
                    state_next = S_R1A;
                end
                else
                begin
                    phase_next = PH_REG2;
                    state_next = S_HX2;
                end
            end
            S_R1A:
            begin
                ctrl.uop   = mer_pkg::UOP_AINC;
                x_next     = x_reg + 1'b1;
                flag_next  = stat.d_neg;
                state_next = S_R1B;
            end
            S_R1B:
            begin
                ctrl.uop   = mer_pkg::UOP_DADDA;
                state_next = S_R1C;
            end
            S_R1C:
            begin
                ctrl.uop   = mer_pkg::UOP_DADDRY2;
                state_next = flag_reg ? S_EMIT : S_R1D;
            end
            S_R1D:
            begin
                ctrl.uop   = mer_pkg::UOP_BDEC;
                y_next     = y_dec;
                state_next = S_R1E;
            end
            S_R1E:
            begin
                ctrl.uop   = mer_pkg::UOP_DSUBB;
                state_next = S_EMIT;
            end

            // region 2 starting decision
            S_HX2:
            begin
                ctrl.uop   = mer_pkg::UOP_HX2;
                state_next = S_DHX;
            end
            S_DHX:
            begin
                ctrl.uop   = mer_pkg::UOP_DHX;
                state_next = S_HY2;
            end
            S_HY2:
            begin
                ctrl.uop   = mer_pkg::UOP_HY2;
                state_next = S_THY;
            end
            S_THY:
            begin
                ctrl.uop   = mer_pkg::UOP_THY;
                state_next = S_DADDT;
            end
            S_DADDT:
            begin
                ctrl.uop   = mer_pkg::UOP_DADDT;
                state_next = S_RXRY;
            end
            S_RXRY:
            begin
                ctrl.uop   = mer_pkg::UOP_RXRY;
                state_next = S_DSUB;
            end
            S_DSUB:
            begin
                ctrl.uop   = mer_pkg::UOP_DSUB4T;
                state_next = S_RND2;
            end
            S_RND2:
            begin
                ctrl.uop   = mer_pkg::UOP_RND;
                state_next = S_R2A;
            end

            // region 2 step
            S_R2A:
            begin
                ctrl.uop   = mer_pkg::UOP_BDEC;
                y_next     = y_dec;
                flag_next  = stat.d_pos;
                state_next = S_R2B;
            end
            S_R2B:
            begin
                ctrl.uop   = mer_pkg::UOP_DSUBB;
                state_next = S_R2C;
            end
            S_R2C:
            begin
                ctrl.uop   = mer_pkg::UOP_DADDRX2;
                state_next = flag_reg ? S_EMIT : S_R2D;
            end
            S_R2D:
            begin
                ctrl.uop   = mer_pkg::UOP_AINC;
                x_next     = x_reg + 1'b1;
                state_next = S_R2E;
            end
            S_R2E:
            begin
                ctrl.uop   = mer_pkg::UOP_DADDA;
                state_next = S_EMIT;
            end

            // hand the point set to the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit.emit = 1'b1;
                    if (pv_reg && (y_reg == '0))
                    begin
                        phase_next = PH_DONE;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            flag_reg  <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            flag_reg  <= flag_next;
            pv_reg    <= pv_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/midpoint_ellipse_rasterizer_unit.sv */
// Top level of the midpoint ellipse rasterizer: center latch, output
// register and coordinate forming. Uses mer_pkg, mer_seq, mer_datapath.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   op, center_x, center_y, radius_x, radius_y
//   output    out_valid / out_ready x_right, x_left, y_down, y_up,
//                                   point_valid, last_point
//
// Per item, from transfer to the next in_ready: a start runs RX2 to RND1;
// a region-1 step runs CMP and R1A to R1C, plus R1D and R1E unless d < 0;
// the step into region 2 runs CMP, HX2 to RND2, then a region-2 step: R2A
// to R2C, plus R2D and R2E unless d > 0; with no run open, only S_EMIT.
// Reset is asynchronous, active low, and leaves the block idle with no run.
// A result waits in the output register while the next item is taken; the
// sequencer only stalls a ready result on a full register with out_ready low.
`default_nettype none

module midpoint_ellipse_rasterizer_unit #(
    parameter int RADIUS_BITS = 9,
    parameter int COORD_BITS  = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic [COORD_BITS-1:0]         center_x,
    input  wire logic [COORD_BITS-1:0]         center_y,
    input  wire logic [RADIUS_BITS-1:0]        radius_x,
    input  wire logic [RADIUS_BITS-1:0]        radius_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [mer_pkg::OUT_W-1:0]   x_right,
    output logic signed [mer_pkg::OUT_W-1:0]   x_left,
    output logic signed [mer_pkg::OUT_W-1:0]   y_down,
    output logic signed [mer_pkg::OUT_W-1:0]   y_up,
    output logic                               point_valid,
    output logic                               last_point
);

    localparam int OW  = mer_pkg::OUT_W;
    localparam int EXA = (COORD_BITS > RADIUS_BITS + 1) ? COORD_BITS : RADIUS_BITS + 1;
    localparam int EXW = ((EXA > OW) ? EXA : OW) + 1;

    mer_pkg::ctrl_t         ctrl;
    mer_pkg::stat_t         stat;
    mer_pkg::emit_t         emit;
    logic [RADIUS_BITS:0]   x_off, y_off;
    logic [RADIUS_BITS+1:0] hx, hy;
    logic                   out_free;

    logic [COORD_BITS-1:0]  cx_reg, cy_reg;
    logic                   out_valid_reg;
    logic [OW-1:0]          x_right_reg, x_left_reg, y_down_reg, y_up_reg;
    logic                   point_valid_reg, last_point_reg;

    logic [EXW-1:0]         cx_e, cy_e, xo_e, yo_e;
    logic [EXW-1:0]         xr_e, xl_e, yd_e, yu_e;

    mer_seq #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .radius_y (radius_y),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl),
        .emit     (emit),
        .x_off    (x_off),
        .y_off    (y_off),
        .hx       (hx),
        .hy       (hy)
    );

    mer_datapath #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .radius_x (radius_x),
        .radius_y (radius_y),
        .hx       (hx),
        .hy       (hy),
        .stat     (stat)
    );

    // output register can take a result this cycle
    assign out_free = !out_valid_reg || out_ready;

    // mirrored coordinates, wrapped to the output width
    assign cx_e = {{(EXW-COORD_BITS){1'b0}}, cx_reg};
    assign cy_e = {{(EXW-COORD_BITS){1'b0}}, cy_reg};
    assign xo_e = {{(EXW-RADIUS_BITS-1){1'b0}}, x_off};
    assign yo_e = {{(EXW-RADIUS_BITS-1){1'b0}}, y_off};
    assign xr_e = cx_e + xo_e;
    assign xl_e = cx_e - xo_e;
    assign yd_e = cy_e + yo_e;
    assign yu_e = cy_e - yo_e;

    // center latch on a start transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (in_valid && in_ready && (op == mer_pkg::OP_START))
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.emit)
        begin
            x_right_reg     <= emit.pv ? xr_e[OW-1:0] : '0;
            x_left_reg      <= emit.pv ? xl_e[OW-1:0] : '0;
            y_down_reg      <= emit.pv ? yd_e[OW-1:0] : '0;
            y_up_reg        <= emit.pv ? yu_e[OW-1:0] : '0;
            point_valid_reg <= emit.pv;
            last_point_reg  <= emit.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign x_right     = x_right_reg;
    assign x_left      = x_left_reg;
    assign y_down      = y_down_reg;
    assign y_up        = y_up_reg;
    assign point_valid = point_valid_reg;
    assign last_point  = last_point_reg;

endmodule

`default_nettype wire

/* hdl/mer_checker.sv */
// Port-level checks of the ellipse rasterizer, bound to its top level.
// Depends on mer_pkg for the coordinate width.
`default_nettype none

module mer_checker #(
    parameter int RADIUS_BITS = 9,
    parameter int COORD_BITS  = 10
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        op,
    input wire logic [COORD_BITS-1:0]       center_x,
    input wire logic [COORD_BITS-1:0]       center_y,
    input wire logic [RADIUS_BITS-1:0]      radius_x,
    input wire logic [RADIUS_BITS-1:0]      radius_y,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [mer_pkg::OUT_W-1:0]   x_right,
    input wire logic [mer_pkg::OUT_W-1:0]   x_left,
    input wire logic [mer_pkg::OUT_W-1:0]   y_down,
    input wire logic [mer_pkg::OUT_W-1:0]   y_up,
    input wire logic                        point_valid,
    input wire logic                        last_point
);

    // every item keeps the sequencer busy, so no two items are taken back to back
    a_busy_after_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input taken twice in back-to-back cycles");

    // a stalled result holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(x_right) && $stable(x_left)
            && $stable(y_down) && $stable(y_up) && $stable(point_valid)
            && $stable(last_point))
    ) else $error("stalled result changed");

    // a step outside a run gives an all-zero set
    a_null_point: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !point_valid) |-> (x_right == '0 && x_left == '0 && y_down == '0
            && y_up == '0 && !last_point)
    ) else $error("invalid point set carries data");

    // the closing set sits on the center row
    a_last_on_axis: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && last_point) |-> (point_valid && (y_down == y_up))
    ) else $error("last point set not on the center row");

    // inputs seen by the checker but not judged here
    logic unused_ok;
    assign unused_ok = ^{op, center_x, center_y, radius_x, radius_y};

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
) u_mer_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .x_right     (x_right),
    .x_left      (x_left),
    .y_down      (y_down),
    .y_up        (y_up),
    .point_valid (point_valid),
    .last_point  (last_point)
);

`default_nettype wire
